[rtl/fixed_block_pool_allocator_top_assert.svh]
// assertion macros for the fixed block pool allocator
// used by fixed_block_pool_allocator_top; expects clock and reset in scope
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define FBPA_ASSERT_HOLD(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define FBPA_ASSERT_HOLD(lbl, ante, cons, msg)
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/fbpa_pkg.sv]
// shared types and constants for the fixed block pool allocator
// no dependencies
`timescale 1ns / 1ps

package fbpa_pkg;

   // default sizing
   localparam int FBPA_NUM_BLOCKS = 256;
   localparam int FBPA_ADDR_BITS  = 32;

   // field widths
   localparam int BSIZE_W  = 17;
   localparam int BCOUNT_W = 9;
   localparam int CSR_AW   = 4;

   // register reset values
   localparam logic [31:0]         DATA_BASE_RST   = 32'd0;
   localparam logic [BSIZE_W-1:0]  BLOCK_SIZE_RST  = 17'd64;
   localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RST = 9'd256;
   localparam logic [31:0]         POOL_SIZE_RST   = 32'd16384;

   // register indexes
   localparam logic [1:0] REG_DATA_BASE   = 2'd0;
   localparam logic [1:0] REG_BLOCK_SIZE  = 2'd1;
   localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;
   localparam logic [1:0] REG_POOL_SIZE   = 2'd3;

   // request kinds
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // result status
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_BAD   = 2'd2
   } status_type;

   // free stack commands
   typedef struct packed {
      logic pop;
      logic push;
      logic rebuild;
   } stk_ctl_type;

endpackage

[rtl/fixed_block_pool_allocator_top.sv]
// Fixed-size block allocator. Free block indices sit on a LIFO stack held in a
// synchronous memory with one read and one write port; after reset or a block_count
// write the stack holds every usable block with the highest index on top, with no
// clearing pass.
// One request is handled at a time. An allocate runs memory read, multiply, add and
// output register in that order. A free runs a bit-serial divider for the block index;
// a free below the base or with a zero block size skips the divider.
// The result register lets a new request be taken while a result still waits.
// The user must write configuration over the csr port only while no request is in
// flight; the block itself does not enforce it.
`timescale 1ns / 1ps
`include "fixed_block_pool_allocator_top_assert.svh"

module fixed_block_pool_allocator_top
   import fbpa_pkg::*;
#(
   parameter int NUM_BLOCKS = FBPA_NUM_BLOCKS,
   parameter int ADDR_BITS  = FBPA_ADDR_BITS
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic [31:0]       req_address,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_block_address,
   output logic [31:0]       rsp_free_space,
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int IW    = $clog2(NUM_BLOCKS);
   localparam int CW    = $clog2(NUM_BLOCKS + 1);
   localparam int AW    = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam int BCW   = (CW > BCOUNT_W) ? CW : BCOUNT_W;
   localparam int QW    = (AW > CW) ? AW : CW;
   localparam int PW    = BSIZE_W + IW;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_ADD  = 5'b00100,
      S_DIV  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   // configuration registers
   logic [31:0]         base_ff;
   logic [BSIZE_W-1:0]  size_ff;
   logic [BCOUNT_W-1:0] bcount_ff;
   logic [31:0]         pool_ff;
   logic                csr_wr;
   logic [1:0]          reg_idx;

   // control and datapath
   state_type           state_ff, state_in;
   logic [31:0]         space_ff, space_in;
   status_type          res_status_ff, res_status_in;
   logic [31:0]         res_addr_ff, res_addr_in;
   logic [PW-1:0]       prod_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [31:0]         rsp_addr_ff;
   logic [31:0]         rsp_space_ff;

   logic                req_take;
   logic                out_free;
   logic [CW-1:0]       cap;
   logic [CW-1:0]       wr_cap;
   logic [31:0]         diff;
   logic [32:0]         addr_sum;
   logic [32:0]         space_up;
   logic [QW-1:0]       q_ext;

   stk_ctl_type         stk_ctl;
   logic [CW-1:0]       stk_count;
   logic [IW-1:0]       pop_idx;

   logic                div_start;
   logic                div_busy;
   logic                div_done;
   logic [AW-1:0]       quotient;

   // register access
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_comb begin
      case (reg_idx)
         REG_DATA_BASE:   csr_prdata = base_ff;
         REG_BLOCK_SIZE:  csr_prdata = 32'(size_ff);
         REG_BLOCK_COUNT: csr_prdata = 32'(bcount_ff);
         REG_POOL_SIZE:   csr_prdata = pool_ff;
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= DATA_BASE_RST;
         size_ff   <= BLOCK_SIZE_RST;
         bcount_ff <= BLOCK_COUNT_RST;
         pool_ff   <= POOL_SIZE_RST;
      end else if (csr_wr) begin
         case (reg_idx)
            REG_DATA_BASE:   base_ff   <= csr_pwdata;
            REG_BLOCK_SIZE:  size_ff   <= csr_pwdata[BSIZE_W-1:0];
            REG_BLOCK_COUNT: bcount_ff <= csr_pwdata[BCOUNT_W-1:0];
            REG_POOL_SIZE:   pool_ff   <= csr_pwdata;
            default:         ;
         endcase
      end
   end

   // usable block count, capped at the stack depth
   assign cap = (BCW'(bcount_ff) > BCW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(bcount_ff);
   assign wr_cap = (BCW'(csr_pwdata[BCOUNT_W-1:0]) > BCW'(NUM_BLOCKS)) ?
                   CW'(NUM_BLOCKS) : CW'(csr_pwdata[BCOUNT_W-1:0]);

   // handshake
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // arithmetic
   assign diff     = req_address - base_ff;
   assign addr_sum = {1'b0, base_ff} + 33'(prod_ff);
   assign space_up = {1'b0, space_ff} + 33'(size_ff);
   assign q_ext    = QW'(quotient);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      space_in      = space_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      stk_ctl       = '0;
      div_start     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               res_addr_in = '0;
               if (req_op == OP_ALLOC) begin
                  if (stk_count == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_OUT;
                  end else begin
                     stk_ctl.pop = 1'b1;
                     state_in    = S_READ;
                  end
               end else begin
                  if ((size_ff == '0) || (req_address < base_ff)) begin
                     res_status_in = ST_BAD;
                     state_in      = S_OUT;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
            end
         end
         S_READ: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            res_status_in = ST_OK;
            res_addr_in   = 32'(addr_sum[AW-1:0]);
            space_in      = (space_ff > 32'(size_ff)) ? (space_ff - 32'(size_ff)) : '0;
            state_in      = S_OUT;
         end
         S_DIV: begin
            if (div_done) begin
               if ((q_ext >= QW'(cap)) || (stk_count >= cap)) begin
                  res_status_in = ST_BAD;
               end else begin
                  res_status_in = ST_OK;
                  stk_ctl.push  = 1'b1;
                  space_in      = space_up[32] ? 32'hFFFF_FFFF : space_up[31:0];
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // block_count write rebuilds the stack, pool_size reloads the free space
      if (csr_wr && (reg_idx == REG_BLOCK_COUNT)) begin
         stk_ctl.rebuild = 1'b1;
      end
      if (csr_wr && (reg_idx == REG_POOL_SIZE)) begin
         space_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         space_ff <= POOL_SIZE_RST;
      end else begin
         state_ff <= state_in;
         space_ff <= space_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      prod_ff       <= size_ff * pop_idx;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_OUT) && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_space_ff  <= space_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_free_space    = rsp_space_ff;

   // free index stack
   fbpa_stack #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_stack (
      .clock       (clock),
      .reset       (reset),
      .ctl         (stk_ctl),
      .push_idx    (quotient[IW-1:0]),
      .rebuild_cap (wr_cap),
      .count       (stk_count),
      .pop_idx     (pop_idx)
   );

   // address to index divider
   fbpa_div #(
      .DW (AW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff[AW-1:0]),
      .divisor  (size_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   // checks
   `FBPA_ASSERT_HOLD(a_count_in_range, 1'b1, stk_count <= cap, "stack count above usable blocks")
   `FBPA_ASSERT_NEXT(a_take_leaves_idle, req_take, state_ff != S_IDLE, "request taken but idle")
   `FBPA_ASSERT_HOLD(a_div_only_in_div, div_busy, state_ff == S_DIV, "divider runs outside free")
   `FBPA_ASSERT_HOLD(a_empty_zero_addr, rsp_valid_ff && (rsp_status_ff == ST_EMPTY),
                     rsp_addr_ff == '0, "failed allocate returned an address")

endmodule

[rtl/fbpa_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on fbpa_pkg
`timescale 1ns / 1ps

module fbpa_div
   import fbpa_pkg::*;
#(
   parameter int DW = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DW-1:0]      dividend,
   input  logic [BSIZE_W-1:0] divisor,
   output logic               busy,
   output logic               done,
   output logic [DW-1:0]      quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]      dvd_ff;
   logic [BSIZE_W-1:0] rem_ff;
   logic [BSIZE_W-1:0] dsr_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;

   logic [BSIZE_W:0]   shifted;
   logic               ge;
   logic [BSIZE_W:0]   sub;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, dvd_ff[DW-1]};
      ge      = shifted >= {1'b0, dsr_ff};
      sub     = shifted - {1'b0, dsr_ff};
   end

   // step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // datapath, quotient bits shift in behind the dividend
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DW-2:0], ge};
         rem_ff <= ge ? sub[BSIZE_W-1:0] : shifted[BSIZE_W-1:0];
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

[rtl/fbpa_stack.sv]
// free index stack in a synchronous memory with a low-water mark
// depends on fbpa_pkg
`timescale 1ns / 1ps

module fbpa_stack
   import fbpa_pkg::*;
#(
   parameter int NUM_BLOCKS = FBPA_NUM_BLOCKS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  stk_ctl_type                         ctl,
   input  logic [$clog2(NUM_BLOCKS)-1:0]       push_idx,
   input  logic [$clog2(NUM_BLOCKS+1)-1:0]     rebuild_cap,
   output logic [$clog2(NUM_BLOCKS+1)-1:0]     count,
   output logic [$clog2(NUM_BLOCKS)-1:0]       pop_idx
);

   localparam int IW = $clog2(NUM_BLOCKS);
   localparam int CW = $clog2(NUM_BLOCKS + 1);
   localparam logic [CW-1:0] RST_CAP =
      (int'(BLOCK_COUNT_RST) > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : CW'(BLOCK_COUNT_RST);

   logic [IW-1:0] stack_mem_ff [NUM_BLOCKS];
   logic [IW-1:0] rd_data_ff;
   logic [IW-1:0] rd_addr_ff;
   logic          bypass_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] low_ff;
   logic [CW-1:0] top_pos;

   // entries below the low-water mark were never written and hold their own position
   assign top_pos = count_ff - CW'(1);

   // memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         stack_mem_ff[count_ff[IW-1:0]] <= push_idx;
      end
      rd_data_ff <= stack_mem_ff[top_pos[IW-1:0]];
      rd_addr_ff <= top_pos[IW-1:0];
      bypass_ff  <= top_pos < low_ff;
   end

   // fill count and low-water mark
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= RST_CAP;
         low_ff   <= RST_CAP;
      end else if (ctl.rebuild) begin
         count_ff <= rebuild_cap;
         low_ff   <= rebuild_cap;
      end else if (ctl.pop) begin
         count_ff <= top_pos;
         if (top_pos < low_ff) begin
            low_ff <= top_pos;
         end
      end else if (ctl.push) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   assign count   = count_ff;
   assign pop_idx = bypass_ff ? rd_addr_ff : rd_data_ff;

endmodule

[verif/tb.sv]
// self-checking testbench for fixed_block_pool_allocator_top: directed plan, then random phases
// depends on fbpa_pkg and the allocator rtl; keeps its own model of the free stack and space count
`timescale 1ns / 1ps

module tb;
   import fbpa_pkg::*;

   // one result transfer
   typedef struct packed {
      status_type  status;
      logic [31:0] block_address;
      logic [31:0] free_space;
   } result_type;

   // one line of the directed plan: a request or a register write
   typedef struct packed {
      logic        is_cfg;
      logic [1:0]  reg_idx;
      logic        op;
      logic [31:0] value;
      logic        typed;
      result_type  want;
   } plan_row_type;

   localparam logic       ROW_REQ  = 1'b0;
   localparam logic       ROW_CFG  = 1'b1;
   localparam logic       TYPED    = 1'b1;
   localparam logic       PREDICT  = 1'b0;
   localparam result_type NO_CHECK = '{ST_OK, 32'd0, 32'd0};

   // directed plan, walked in order before the random phases
   localparam plan_row_type DIRECTED_PLAN [0:33] = '{
      '{ROW_REQ, REG_DATA_BASE,   OP_ALLOC, 32'h0000_0000, TYPED,
        '{ST_OK, 32'd16320, 32'd16320}},
      // unaligned free of the top block
      '{ROW_REQ, REG_DATA_BASE,   OP_FREE,  32'd16383,     TYPED,
        '{ST_OK, 32'd0, 32'd16384}},
      // stack already full
      '{ROW_REQ, REG_DATA_BASE,   OP_FREE,  32'h0000_0000, TYPED,
        '{ST_BAD, 32'd0, 32'd16384}},
      '{ROW_REQ, REG_DATA_BASE,   OP_ALLOC, 32'hFFFF_FFFF, TYPED,
        '{ST_OK, 32'd16320, 32'd16320}},
      '{ROW_REQ, REG_DATA_BASE,   OP_ALLOC, 32'h0000_0000, TYPED,
        '{ST_OK, 32'd16256, 32'd16256}},
      // index far out of range
      '{ROW_REQ, REG_DATA_BASE,   OP_FREE,  32'hFFFF_FFFF, TYPED,
        '{ST_BAD, 32'd0, 32'd16256}},
      '{ROW_REQ, REG_DATA_BASE,   OP_FREE,  32'd16256,     PREDICT, NO_CHECK},
      '{ROW_CFG, REG_DATA_BASE,   OP_ALLOC, 32'h0000_1000, PREDICT, NO_CHECK},
      // address below base
      '{ROW_REQ, REG_DATA_BASE,   OP_FREE,  32'h0000_0FFF, TYPED,
        '{ST_BAD, 32'd0, 32'd16320}},
      '{ROW_REQ, REG_DATA_BASE,   OP_FREE,  32'h0000_1000, PREDICT, NO_CHECK},
      // zero block size
      '{ROW_CFG, REG_BLOCK_SIZE,  OP_ALLOC, 32'd0,         PREDICT, NO_CHECK},
      '{ROW_REQ, REG_DATA_BASE,   OP_ALLOC, 32'h5555_5555, PREDICT, NO_CHECK},
      '{ROW_REQ, REG_DATA_BASE,   OP_FREE,  32'h0000_1000, PREDICT, NO_CHECK},
      '{ROW_CFG, REG_BLOCK_SIZE,  OP_ALLOC, 32'h0001_0000, PREDICT, NO_CHECK},
      '{ROW_CFG, REG_BLOCK_COUNT, OP_ALLOC, 32'd2,         PREDICT, NO_CHECK},
      '{ROW_CFG, REG_POOL_SIZE,   OP_ALLOC, 32'hFFFF_FFFF, PREDICT, NO_CHECK},
      '{ROW_REQ, REG_DATA_BASE,   OP_FREE,  32'h0000_1000, TYPED,
        '{ST_BAD, 32'd0, 32'hFFFF_FFFF}},
      '{ROW_REQ, REG_DATA_BASE,   OP_ALLOC, 32'hAAAA_AAAA, TYPED,
        '{ST_OK, 32'h0001_1000, 32'hFFFE_FFFF}},
      '{ROW_REQ, REG_DATA_BASE,   OP_ALLOC, 32'h0000_0000, TYPED,
        '{ST_OK, 32'h0000_1000, 32'hFFFD_FFFF}},
      // empty stack
      '{ROW_REQ, REG_DATA_BASE,   OP_ALLOC, 32'h0000_0000, TYPED,
        '{ST_EMPTY, 32'd0, 32'hFFFD_FFFF}},
      // free space saturates at the top
      '{ROW_CFG, REG_POOL_SIZE,   OP_ALLOC, 32'hFFFF_FFF0, PREDICT, NO_CHECK},
      '{ROW_REQ, REG_DATA_BASE,   OP_FREE,  32'h0001_FFFF, PREDICT, NO_CHECK},
      '{ROW_REQ, REG_DATA_BASE,   OP_FREE,  32'h0002_1000, PREDICT, NO_CHECK},
      // free space saturates at zero
      '{ROW_CFG, REG_POOL_SIZE,   OP_ALLOC, 32'd5,         PREDICT, NO_CHECK},
      '{ROW_REQ, REG_DATA_BASE,   OP_ALLOC, 32'h0000_0000, PREDICT, NO_CHECK},
      '{ROW_REQ, REG_DATA_BASE,   OP_FREE,  32'h0000_0000, PREDICT, NO_CHECK},
      // block count above the stack depth
      '{ROW_CFG, REG_BLOCK_COUNT, OP_ALLOC, 32'd300,       PREDICT, NO_CHECK},
      '{ROW_REQ, REG_DATA_BASE,   OP_ALLOC, 32'h0000_0000, PREDICT, NO_CHECK},
      // block address wraps past the top
      '{ROW_CFG, REG_DATA_BASE,   OP_ALLOC, 32'hFFFF_F000, PREDICT, NO_CHECK},
      '{ROW_REQ, REG_DATA_BASE,   OP_ALLOC, 32'h0000_0000, PREDICT, NO_CHECK},
      '{ROW_REQ, REG_DATA_BASE,   OP_FREE,  32'hFFFF_FFFF, PREDICT, NO_CHECK},
      // no usable blocks at all
      '{ROW_CFG, REG_BLOCK_COUNT, OP_ALLOC, 32'd0,         PREDICT, NO_CHECK},
      '{ROW_REQ, REG_DATA_BASE,   OP_ALLOC, 32'h0000_0000, PREDICT, NO_CHECK},
      '{ROW_REQ, REG_DATA_BASE,   OP_FREE,  32'hFFFF_F000, PREDICT, NO_CHECK}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_op = OP_ALLOC;
   logic [31:0]       req_address = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [31:0]       rsp_block_address;
   logic [31:0]       rsp_free_space;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   fixed_block_pool_allocator_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_block_address(rsp_block_address),
      .rsp_free_space   (rsp_free_space),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #5 clock = ~clock;

   // allocator model state
   logic [31:0]         cfg_base;
   logic [BSIZE_W-1:0]  cfg_bsize;
   logic [BCOUNT_W-1:0] cfg_bcount;
   logic [7:0]          free_indices [0:255];
   int unsigned         stack_depth;
   logic [31:0]         space_left_pred;

   result_type  pending_results [$];
   logic [31:0] held_blocks [$];
   int          fail_count = 0;
   int          results_seen = 0;
   int          burst_left = 0;

   function automatic int unsigned usable_blocks();
      return (cfg_bcount > 9'd256) ? 256 : int'(cfg_bcount);
   endfunction

   function automatic void rebuild_free_stack();
      for (int i = 0; i < 256; i++) begin
         free_indices[i] = i[7:0];
      end
      stack_depth = usable_blocks();
   endfunction

   // register write as seen by the allocator
   function automatic void apply_register(input logic [1:0] idx, input logic [31:0] value);
      case (idx)
         REG_DATA_BASE: cfg_base = value;
         REG_BLOCK_SIZE: cfg_bsize = value[BSIZE_W-1:0];
         REG_BLOCK_COUNT: begin
            cfg_bcount = value[BCOUNT_W-1:0];
            rebuild_free_stack();
         end
         REG_POOL_SIZE: space_left_pred = value;
         default: ;
      endcase
   endfunction

   // one request against the model: pop or push an index, move the space count
   function automatic result_type allocator_step(input logic op, input logic [31:0] addr);
      result_type  res;
      logic [63:0] idx;
      logic [63:0] sum;
      int unsigned cap;
      res.status = ST_OK;
      res.block_address = '0;
      cap = usable_blocks();
      if (op == OP_ALLOC) begin
         if (stack_depth == 0) begin
            res.status = ST_EMPTY;
         end else begin
            stack_depth--;
            idx = {56'd0, free_indices[stack_depth]};
            sum = {32'd0, cfg_base} + {47'd0, cfg_bsize} * idx;
            res.block_address = sum[31:0];
            space_left_pred = (space_left_pred > {15'd0, cfg_bsize}) ?
                              space_left_pred - {15'd0, cfg_bsize} : 32'd0;
         end
      end else if (cfg_bsize == '0 || addr < cfg_base) begin
         res.status = ST_BAD;
      end else begin
         idx = {32'd0, addr - cfg_base} / {47'd0, cfg_bsize};
         if (idx >= 64'(cap) || stack_depth >= cap) begin
            res.status = ST_BAD;
         end else begin
            free_indices[stack_depth] = idx[7:0];
            stack_depth++;
            sum = {32'd0, space_left_pred} + {47'd0, cfg_bsize};
            space_left_pred = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
         end
      end
      res.free_space = space_left_pred;
      return res;
   endfunction

   // offer one request and hold it until the transfer
   task automatic issue_request(input logic op, input logic [31:0] addr,
                                input logic typed, input result_type typed_res);
      result_type res;
      result_type expected;
      req_op <= op;
      req_address <= addr;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = allocator_step(op, addr);
      if (op == OP_ALLOC && res.status == ST_OK) begin
         held_blocks = {held_blocks, res.block_address};
      end
      expected = typed ? typed_res : res;
      pending_results = {pending_results, expected};
   endtask

   // bursts of random length, most of them after a random gap
   task automatic pace();
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      burst_left--;
   endtask

   // stop offering and let every outstanding result come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // setup and access cycles of a register write, then the select is dropped
   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      csr_pwrite <= 1'b1;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      apply_register(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // receiver stall pattern, with one long hold-off to back up the request side
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 250) begin
         rsp_stall <= 1'b1;
         hold_left <= 400;
         hold_done <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(5, 60);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // compare each result transfer with the oldest prediction
   result_type oldest;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing pending: status %0d address %h space %h",
                     $time, rsp_status, rsp_block_address, rsp_free_space);
            fail_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_status !== oldest.status) begin
               $display("%0t: status expected %0d actual %0d", $time, oldest.status, rsp_status);
               fail_count++;
            end
            if (rsp_block_address !== oldest.block_address) begin
               $display("%0t: block_address expected %h actual %h",
                        $time, oldest.block_address, rsp_block_address);
               fail_count++;
            end
            if (rsp_free_space !== oldest.free_space) begin
               $display("%0t: free_space expected %h actual %h",
                        $time, oldest.free_space, rsp_free_space);
               fail_count++;
            end
         end
      end
   end

   // stimulus: directed plan, then random phases
   initial begin : stimulus
      logic [31:0]        base;
      logic [BSIZE_W-1:0] bsize;
      logic [31:0]        bcount;
      logic [31:0]        pool;
      logic               op;
      logic [31:0]        addr;
      int                 pick;
      int                 k;

      cfg_base = DATA_BASE_RST;
      cfg_bsize = BLOCK_SIZE_RST;
      cfg_bcount = BLOCK_COUNT_RST;
      rebuild_free_stack();
      space_left_pred = POOL_SIZE_RST;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_PLAN[i]) begin
         if (DIRECTED_PLAN[i].is_cfg == ROW_CFG) begin
            wait_idle();
            write_register(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].value);
         end else begin
            pace();
            issue_request(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].value,
                          DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
         end
      end

      for (int phase = 0; phase < 6; phase++) begin
         // first two phases hold the register extremes
         case (phase)
            0: begin
               base = 32'd0;
               bsize = 17'd1;
               bcount = 32'd256;
               pool = 32'd0;
            end
            1: begin
               base = 32'hFFFF_FFFF;
               bsize = 17'h1_0000;
               bcount = 32'd511;
               pool = 32'hFFFF_FFFF;
            end
            default: begin
               base = ($urandom_range(0, 1) == 0) ? $urandom : ($urandom & 32'h000F_FFFF);
               case ($urandom_range(0, 3))
                  0: bsize = 17'($urandom_range(1, 64));
                  1: bsize = 17'd1 << $urandom_range(0, 16);
                  2: bsize = 17'($urandom_range(1, 65536));
                  default: bsize = 17'($urandom_range(1, 4096));
               endcase
               bcount = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 12);
               pool = $urandom;
            end
         endcase
         wait_idle();
         write_register(REG_DATA_BASE, base);
         write_register(REG_BLOCK_SIZE, {15'd0, bsize});
         write_register(REG_POOL_SIZE, pool);
         write_register(REG_BLOCK_COUNT, bcount);
         held_blocks.delete();

         for (int n = 0; n < 100; n++) begin
            pace();
            pick = $urandom_range(0, 99);
            addr = $urandom;
            if (pick < 45) begin
               op = OP_ALLOC;
            end else if (pick < 85 && held_blocks.size() != 0) begin
               // release a live block, anywhere inside it
               op = OP_FREE;
               k = $urandom_range(0, held_blocks.size() - 1);
               addr = held_blocks[k];
               if (cfg_bsize > 1) begin
                  addr = addr + $urandom_range(0, cfg_bsize - 1);
               end
               held_blocks.delete(k);
            end else begin
               // noise: random, just below base, or a block index that may be stale or too high
               op = OP_FREE;
               case ($urandom_range(0, 2))
                  0: ;
                  1: addr = cfg_base - $urandom_range(1, 16);
                  default: addr = cfg_base + cfg_bsize * $urandom_range(0, 300);
               endcase
            end
            issue_request(op, addr, PREDICT, NO_CHECK);
         end
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

[fixed_block_pool_allocator_top.f]
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_div.sv
rtl/fbpa_stack.sv
rtl/fixed_block_pool_allocator_top.sv
verif/tb.sv
